/* design/tmps_pkg.sv */
// ----------------------------------------------------------------------------
// tmps_pkg
// Shared types and constants for the triangle maximum path sum block.
// ----------------------------------------------------------------------------
package tmps_pkg;

   // field widths
   localparam int WEIGHT_W     = 16;
   localparam int SUM_W        = 23;
   localparam int ROWCNT_W     = 8;
   localparam int START_W      = 7;
   localparam int CFG_IDX_W    = 2;
   localparam int CFG_DATA_W   = 8;
   localparam int MAX_ROWS_DEF = 128;

   // saturation ceiling of a path sum
   localparam logic [SUM_W-1:0] SUM_TOP = {SUM_W{1'b1}};

   // configuration register indexes
   localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
   localparam logic [CFG_IDX_W-1:0] REG_START_ROW = 2'd1;
   localparam logic [CFG_IDX_W-1:0] REG_START_COL = 2'd2;

   // one row buffer entry: best sum into a cell and its reach bit
   typedef struct packed {
      logic             reach;
      logic [SUM_W-1:0] best;
   } entry_type;

endpackage

/* design/tmps_cell.sv */
// ----------------------------------------------------------------------------
// tmps_cell
// One row buffer cell: shifts its entry toward the head on every transfer,
// or loads a fresh entry when it is the current write position.
// ----------------------------------------------------------------------------
module tmps_cell
   import tmps_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      shift,
   input  logic      load,
   input  entry_type neighbor,
   input  entry_type fresh,
   output entry_type entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // pick shifted or fresh entry
   always_comb begin
      entry_in = entry_ff;
      if (shift) begin
         entry_in = load ? fresh : neighbor;
      end
   end

   // reach bit cleared by reset, sum is payload
   always_ff @(posedge clock) begin
      entry_ff.best <= entry_in.best;
      if (reset) begin
         entry_ff.reach <= 1'b0;
      end else begin
         entry_ff.reach <= entry_in.reach;
      end
   end

   assign entry = entry_ff;

endmodule

/* design/tmps_chain.sv */
// ----------------------------------------------------------------------------
// tmps_chain
// Row buffer as a chain of cells. The head cell always holds the previous
// row's entry for the current column; a new entry enters at the position
// equal to the current row so that it reaches the head one row later.
// ----------------------------------------------------------------------------
module tmps_chain
   import tmps_pkg::*;
#(
   parameter int MAX_ROWS = MAX_ROWS_DEF,
   parameter int IDX_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             shift,
   input  logic [IDX_W-1:0] wr_pos,
   input  entry_type        fresh,
   output entry_type        head
);

   entry_type cells [MAX_ROWS];
   entry_type feed  [MAX_ROWS];

   // tail cell is fed with an empty entry
   always_comb begin
      for (int i = 0; i < MAX_ROWS; i++) begin
         if (i == MAX_ROWS - 1) begin
            feed[i] = '0;
         end else begin
            feed[i] = cells[i + 1];
         end
      end
   end

   // cell row
   for (genvar g = 0; g < MAX_ROWS; g++) begin : g_cell
      tmps_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (shift),
         .load     (wr_pos == IDX_W'(g)),
         .neighbor (feed[g]),
         .fresh    (fresh),
         .entry    (cells[g])
      );
   end

   assign head = cells[0];

endmodule

/* design/triangle_max_path_sum.sv */
// ----------------------------------------------------------------------------
// triangle_max_path_sum
// Largest path sum through a number triangle, streamed in row-major order,
// from a configured start cell down to the last row.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  req     | in  | req_tvalid/tready   | tdata[15:0] weight
//  rsp     | out | rsp_tvalid/tready   | tdata[22:0] best_sum, tuser[0] start_ok
//  csr     | in  | csr_valid/ready     | csr_index register, csr_data value
//
//  One weight per cycle unless the input is stalled; the row buffer chain
//  shifts once per weight. The result of a triangle is registered in the
//  step stage, then in the final-max stage, before it appears.
//  Reset clears position, reach bits and the pipeline; no clearing pass.
//  A held result stalls the input only once the next result is ready.
// ----------------------------------------------------------------------------
module triangle_max_path_sum
   import tmps_pkg::*;
#(
   parameter int MAX_ROWS = MAX_ROWS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   // weight stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // [15:0] weight
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,   // [22:0] best_sum, [23] zero
   output logic [0:0]            rsp_tuser,   // [0] start_ok
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CFG_IDX_W-1:0]  csr_index,
   input  logic [CFG_DATA_W-1:0] csr_data
);

   localparam int IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CMP_W = ((IDX_W > ROWCNT_W) ? IDX_W : ROWCNT_W) + 2;

   // configuration registers
   logic [ROWCNT_W-1:0] row_count_ff;
   logic [START_W-1:0]  start_row_ff;
   logic [START_W-1:0]  start_col_ff;

   // step stage state
   logic [IDX_W-1:0] row_ff, row_in;
   logic [IDX_W-1:0] col_ff, col_in;
   entry_type        left_ff, left_in;

   // final-max stage
   logic             s2_valid_ff;
   logic [SUM_W-1:0] s2_best_ff;
   logic             s2_reach_ff;
   logic             s2_last_ff;
   logic             s2_end_ff;
   logic             s2_ok_ff;
   logic [SUM_W-1:0] final_best_ff, final_best_in;
   logic             final_found_ff, final_found_in;

   // output register
   logic             rsp_valid_ff;
   logic [SUM_W-1:0] rsp_sum_ff;
   logic             rsp_ok_ff;

   logic             accept;
   logic             s2_move;
   entry_type        head;
   entry_type        fresh;
   entry_type        above;
   logic [CMP_W-1:0] rows;
   logic             last_row;
   logic             start_ok;
   logic             at_start;
   logic             below_start;
   logic             left_ok;
   logic [SUM_W-1:0] pred;
   logic [SUM_W:0]   raw_sum;
   logic             row_done;
   logic             take_final;

   // configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= ROWCNT_W'(1);
         start_row_ff <= '0;
         start_col_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_ROW_COUNT: row_count_ff <= csr_data[ROWCNT_W-1:0];
            REG_START_ROW: start_row_ff <= csr_data[START_W-1:0];
            REG_START_COL: start_col_ff <= csr_data[START_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline flow: the final stage stalls only on an undelivered result
   assign s2_move    = !s2_valid_ff || !s2_end_ff || !rsp_valid_ff || rsp_tready;
   assign req_tready = s2_move;
   assign accept     = req_tvalid && req_tready;

   // rows in use, clamped to 1..MAX_ROWS
   always_comb begin
      rows = CMP_W'(row_count_ff);
      if (row_count_ff == '0) begin
         rows = CMP_W'(1);
      end else if (CMP_W'(row_count_ff) > CMP_W'(MAX_ROWS)) begin
         rows = CMP_W'(MAX_ROWS);
      end
   end

   assign last_row    = (CMP_W'(row_ff) + CMP_W'(1)) >= rows;
   assign start_ok    = (CMP_W'(start_row_ff) < rows) && (start_col_ff <= start_row_ff);
   assign at_start    = (CMP_W'(row_ff) == CMP_W'(start_row_ff)) &&
                        (CMP_W'(col_ff) == CMP_W'(start_col_ff));
   assign below_start = CMP_W'(row_ff) > CMP_W'(start_row_ff);
   assign row_done    = (col_ff == row_ff);

   // previous-row entry above this column, valid only left of the diagonal
   always_comb begin
      above = '0;
      if ((col_ff < row_ff) && head.reach) begin
         above = head;
      end
   end

   assign left_ok = (col_ff != '0) && left_ff.reach;

   // best predecessor and saturating add
   always_comb begin
      pred = above.best;
      if (left_ok && (!above.reach || left_ff.best > above.best)) begin
         pred = left_ff.best;
      end
      raw_sum = {1'b0, pred} + (SUM_W + 1)'(req_tdata);
   end

   // new entry for this cell
   always_comb begin
      fresh = '0;
      if (at_start) begin
         fresh.reach = 1'b1;
         fresh.best  = SUM_W'(req_tdata);
      end else if (below_start && (above.reach || left_ok)) begin
         fresh.reach = 1'b1;
         fresh.best  = raw_sum[SUM_W] ? SUM_TOP : raw_sum[SUM_W-1:0];
      end
   end

   // position update
   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      left_in = left_ff;
      if (accept) begin
         left_in = above;
         if (row_done) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + IDX_W'(1);
         end else begin
            col_in = col_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         left_ff <= '0;
      end else begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         left_ff <= left_in;
      end
   end

   tmps_chain #(
      .MAX_ROWS (MAX_ROWS),
      .IDX_W    (IDX_W)
   ) u_chain (
      .clock  (clock),
      .reset  (reset),
      .shift  (accept),
      .wr_pos (row_ff),
      .fresh  (fresh),
      .head   (head)
   );

   // step results into the final-max stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_move) begin
         s2_valid_ff <= accept;
      end
      if (s2_move && accept) begin
         s2_best_ff  <= fresh.best;
         s2_reach_ff <= fresh.reach;
         s2_last_ff  <= last_row;
         s2_end_ff   <= last_row && row_done;
         s2_ok_ff    <= start_ok;
      end
   end

   // running maximum over the last row
   assign take_final = s2_last_ff && s2_reach_ff &&
                       (!final_found_ff || s2_best_ff > final_best_ff);

   always_comb begin
      final_best_in  = take_final ? s2_best_ff : final_best_ff;
      final_found_in = final_found_ff || take_final;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         final_best_ff  <= '0;
         final_found_ff <= 1'b0;
      end else if (s2_valid_ff && s2_move) begin
         if (s2_end_ff) begin
            final_best_ff  <= '0;
            final_found_ff <= 1'b0;
         end else begin
            final_best_ff  <= final_best_in;
            final_found_ff <= final_found_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_valid_ff && s2_move && s2_end_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (s2_valid_ff && s2_move && s2_end_ff) begin
         rsp_sum_ff <= (s2_ok_ff && final_found_in) ? final_best_in : '0;
         rsp_ok_ff  <= s2_ok_ff;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {1'b0, rsp_sum_ff};
   assign rsp_tuser[0] = rsp_ok_ff;

   // an invalid start never reports a sum
   a_bad_start_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ok_ff |-> rsp_sum_ff == '0)
      else $error("nonzero sum with start outside triangle");

   // column never passes the diagonal
   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      col_ff <= row_ff)
      else $error("column beyond diagonal");

   // an unreachable cell carries no sum
   a_unreach_zero: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !s2_reach_ff |-> s2_best_ff == '0)
      else $error("sum on unreachable cell");

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !s2_valid_ff && !rsp_valid_ff)
      else $error("pipeline not empty after reset");

   // the input only stalls behind a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s2_valid_ff && s2_end_ff && rsp_valid_ff)
      else $error("input stalled without waiting result");

endmodule
